### sv/cws_pkg.sv
// shared types and constants of the cross window sorter
`default_nettype none

package cws_pkg;

  // line store geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int CH_W       = 3;
  localparam int PIX_W      = 8;

  // window queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  // one gathered cross window, unsorted
  typedef struct packed {
    pix_t centre;
    pix_t up;
    pix_t right;
    pix_t down;
    pix_t left;
    logic last;
  } window_t;

  // front to queue write
  typedef struct packed {
    logic    valid;
    window_t data;
  } win_push_t;

endpackage

`default_nettype wire

### sv/cws_front.sv
// front end: configuration, raster counters, line stores and window gathering
`default_nettype none

module cws_front import cws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,
  input  logic [QCNT_W-1:0] fifo_count,
  output win_push_t         push
);

  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;
  logic [CH_W-1:0]  n_ch;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [1:0]       chan;

  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             col_end;
  logic             row_end;
  logic             chan_end;
  logic             accept;
  logic             is_pix;
  logic             right_ok;
  logic             emit;
  logic             last;
  logic [COL_W-1:0] col_right;

  pix_t upper_mem  [MAX_WIDTH];
  pix_t centre_mem [MAX_WIDTH];

  pix_t up_rd;
  pix_t ctr_rd;
  pix_t right_rd;
  pix_t left_tap;

  logic             s1_valid;
  logic             s1_emit;
  logic             s1_last;
  logic             s1_right_ok;
  pix_t             s1_sample;
  logic [COL_W-1:0] s1_addr;

  // configuration writes, clamped on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= DIM_W'(MAX_WIDTH);
      img_h <= DIM_W'(MAX_HEIGHT);
      n_ch  <= CH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_data < DIM_W'(3)) img_w <= DIM_W'(3);
          else if (cfg_data > DIM_W'(MAX_WIDTH)) img_w <= DIM_W'(MAX_WIDTH);
          else img_w <= cfg_data;
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data < DIM_W'(3)) img_h <= DIM_W'(3);
          else if (cfg_data > DIM_W'(MAX_HEIGHT)) img_h <= DIM_W'(MAX_HEIGHT);
          else img_h <= cfg_data;
        end
        REG_CHANNEL_COUNT: begin
          if (cfg_data[CH_W-1:0] == CH_W'(0)) n_ch <= CH_W'(1);
          else if (cfg_data[CH_W-1:0] > CH_W'(4)) n_ch <= CH_W'(4);
          else n_ch <= cfg_data[CH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // position decode for the incoming byte
  assign accept    = s_tvalid && s_tready;
  assign is_pix    = (chan == 2'd0);
  assign col_inc   = DIM_W'(col) + DIM_W'(1);
  assign row_inc   = DIM_W'(row) + DIM_W'(1);
  assign col_end   = (col_inc >= img_w);
  assign row_end   = (row_inc >= img_h);
  assign chan_end  = ((CH_W'(chan) + CH_W'(1)) >= n_ch);
  assign right_ok  = (col_inc < img_w);
  assign col_right = col + COL_W'(1);
  assign emit      = (row >= ROW_W'(2)) && (DIM_W'(row) < img_h) && (col != '0) && right_ok;
  assign last      = (row_inc == img_h) && ((DIM_W'(col) + DIM_W'(2)) == img_w);

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      chan <= '0;
    end else if (accept) begin
      if (chan_end) begin
        chan <= '0;
        if (col_end) begin
          col <= '0;
          row <= row_end ? '0 : row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end else begin
        chan <= chan + 2'd1;
      end
    end
  end

  // line stores: reads at accept, upper row written back in the cycle after
  always_ff @(posedge clk) begin
    if (accept && is_pix) begin
      up_rd            <= upper_mem[col];
      ctr_rd           <= centre_mem[col];
      right_rd         <= centre_mem[col_right];
      centre_mem[col]  <= s_tdata;
    end
    if (s1_valid) begin
      upper_mem[s1_addr] <= ctr_rd;
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
      left_tap <= '0;
    end else begin
      s1_valid <= accept && is_pix;
      s1_emit  <= accept && is_pix && emit;
      if (s1_valid) begin
        left_tap <= ctr_rd;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept && is_pix) begin
      s1_last     <= last;
      s1_right_ok <= right_ok;
      s1_sample   <= s_tdata;
      s1_addr     <= col;
    end
  end

  // window handed to the queue
  always_comb begin
    push.valid       = s1_valid && s1_emit;
    push.data.centre = ctr_rd;
    push.data.up     = up_rd;
    push.data.right  = s1_right_ok ? right_rd : '0;
    push.data.down   = s1_sample;
    push.data.left   = left_tap;
    push.data.last   = s1_last;
  end

  // room for the queued windows, the one in flight and the next one
  assign s_tready = ((QCNT_W+1)'(fifo_count) + (QCNT_W+1)'(push.valid))
                    < (QCNT_W+1)'(QUEUE_DEPTH);

endmodule

`default_nettype wire

### sv/cws_fifo.sv
// short window queue between front and back
`default_nettype none

module cws_fifo import cws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  win_push_t         push,
  input  logic              pop,
  output window_t           head,
  output logic [QCNT_W-1:0] count
);

  window_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push.valid) - QCNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.data;
    end
  end

  assign head = slots[rd_ptr];

endmodule

`default_nettype wire

### sv/cws_back.sv
// back end: five-input sorting network and output register
`default_nettype none

module cws_back import cws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  window_t              head,
  input  logic                 avail,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [5*PIX_W-1:0]   m_tdata,
  output logic                 m_tlast
);

  pix_t v [5];

  // compare-exchange, smaller value in the upper half
  function automatic logic [2*PIX_W-1:0] order2(input pix_t a, input pix_t b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  // nine-comparator network
  always_comb begin
    v[0] = head.centre;
    v[1] = head.up;
    v[2] = head.right;
    v[3] = head.down;
    v[4] = head.left;
    {v[0], v[1]} = order2(v[0], v[1]);
    {v[3], v[4]} = order2(v[3], v[4]);
    {v[2], v[4]} = order2(v[2], v[4]);
    {v[2], v[3]} = order2(v[2], v[3]);
    {v[0], v[3]} = order2(v[0], v[3]);
    {v[0], v[2]} = order2(v[0], v[2]);
    {v[1], v[4]} = order2(v[1], v[4]);
    {v[1], v[3]} = order2(v[1], v[3]);
    {v[1], v[2]} = order2(v[1], v[2]);
  end

  assign pop = avail && (!m_tvalid || m_tready);

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {v[4], v[3], v[2], v[1], v[0]};
      m_tlast <= head.last;
    end
  end

endmodule

`default_nettype wire

### sv/cross_window_sorter.sv
// top level of the five-point cross window sorter
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata[7:0] sample_byte
// m_*      out  m_tvalid/m_tready   m_tdata sorted_0..sorted_4, m_tlast last_window
// cfg_*    in   cfg_we              cfg_index register, cfg_data value
//
// one input byte per clock while s_tready is high; a window passes from the byte
// carrying its down neighbour through the line store read, the queue slot and
// the output register
// rst clears counters, queue and output valid and loads register defaults;
// the line stores are not cleared
// s_tready falls only when the four-entry window queue could overfill

`default_nettype none

module cross_window_sorter import cws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [DIM_W-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [PIX_W-1:0]    s_tdata,   // [7:0] sample_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [5*PIX_W-1:0]  m_tdata,   // sorted_0 [7:0] .. sorted_4 [39:32]
  output logic                m_tlast
);

  win_push_t         push;
  window_t           head;
  logic              pop;
  logic [QCNT_W-1:0] fifo_count;

  cws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .fifo_count (fifo_count),
    .push       (push)
  );

  cws_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (fifo_count)
  );

  cws_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .avail    (fifo_count != '0),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // queue never written while full unless it is also popped in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid && !pop |-> fifo_count < QCNT_W'(QUEUE_DEPTH))
    else $error("window queue overflow");

  // a full queue never coexists with an accepted byte
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> fifo_count < QCNT_W'(QUEUE_DEPTH))
    else $error("input ready with full queue");

  // reset leaves queue and output empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && fifo_count == '0)
    else $error("state left after reset");

endmodule

`default_nettype wire

### bench/tb_cross_window_sorter.sv
// self-checking testbench for the cross window sorter: raster stimulus, window prediction, checks
`timescale 1ns / 1ps

module tb_cross_window_sorter;
  import cws_pkg::*;

  // one sorted cross window as it leaves the block
  typedef struct packed {
    logic [4:0][PIX_W-1:0] ranked;
    logic                  is_last;
  } ranked_window_t;

  // input transactions sent over the whole run
  localparam int unsigned ITEM_TARGET = 900;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]   cfg_data  = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [PIX_W-1:0]   s_tdata   = '0;   // [7:0] sample_byte
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [5*PIX_W-1:0] m_tdata;          // sorted_0 [7:0] .. sorted_4 [39:32]
  logic               m_tlast;          // last_window

  cross_window_sorter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // shadow registers and line stores of the predictor
  logic [DIM_W-1:0] width_reg  = 11'd1024;
  logic [DIM_W-1:0] height_reg = 11'd1024;
  logic [CH_W-1:0]  chan_reg   = 3'd1;
  pix_t             upper_line  [MAX_WIDTH];
  pix_t             centre_line [MAX_WIDTH];
  pix_t             centre_taps [3];
  int unsigned      pred_col = 0, pred_row = 0, pred_ch = 0;

  // raster position of the stimulus generator, ahead of the predictor
  int unsigned      gen_col = 0, gen_row = 0, gen_ch = 0;

  pix_t             byte_backlog [$];
  ranked_window_t   pending_windows [$];

  int tx_idle_pct = 22;
  int rx_idle_pct = 56;
  int mismatches = 0;
  int bytes_accepted = 0;
  int windows_checked = 0;
  int last_marks = 0;
  int setups = 0;
  int unsigned bytes_queued = 0;

  // clock
  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clamp_dim(width_reg, 3, MAX_WIDTH);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_dim(height_reg, 3, MAX_HEIGHT);
  endfunction

  function automatic int unsigned eff_channels();
    return clamp_dim(chan_reg, 1, 4);
  endfunction

  // channel, then column, then row; counters past a shrunken limit wrap at once
  function automatic void advance_position(inout int unsigned col, inout int unsigned row,
                                           inout int unsigned ch);
    if (ch + 1 >= eff_channels()) begin
      ch = 0;
      if (col + 1 >= eff_width()) begin
        col = 0;
        if (row + 1 >= eff_height()) row = 0;
        else row++;
      end else begin
        col++;
      end
    end else begin
      ch++;
    end
  endfunction

  // one byte into the predictor; returns 1 when it completes an interior window
  function automatic bit cross_window_step(input pix_t sample, output ranked_window_t res);
    int unsigned w;
    int unsigned h;
    int unsigned ci;
    int          i;
    int          j;
    pix_t        up_px;
    pix_t        ctr_px;
    pix_t        right_px;
    pix_t        hold;
    pix_t        win [5];
    bit          hit;
    w   = eff_width();
    h   = eff_height();
    hit = 1'b0;
    res = '0;
    if (pred_ch == 0) begin
      ci       = pred_col % MAX_WIDTH;
      up_px    = upper_line[ci];
      ctr_px   = centre_line[ci];
      right_px = (pred_col + 1 < w) ? centre_line[(pred_col + 1) % MAX_WIDTH] : '0;
      centre_taps[0] = centre_taps[1];
      centre_taps[1] = ctr_px;
      centre_taps[2] = right_px;
      if (pred_row >= 2 && pred_row < h && pred_col >= 1 && pred_col + 1 < w) begin
        // centre, up, right, down (this byte), left
        win = '{centre_taps[1], up_px, centre_taps[2], sample, centre_taps[0]};
        for (i = 1; i < 5; i++) begin
          j = i;
          while (j > 0 && win[j-1] > win[j]) begin
            hold     = win[j];
            win[j]   = win[j-1];
            win[j-1] = hold;
            j--;
          end
        end
        for (i = 0; i < 5; i++) res.ranked[i] = win[i];
        res.is_last = (pred_row + 1 == h) && (pred_col + 2 == w);
        hit = 1'b1;
      end
      upper_line[ci]  = ctr_px;
      centre_line[ci] = sample;
    end
    advance_position(pred_col, pred_row, pred_ch);
    return hit;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // sample driver: holds a transaction until taken, predicts on acceptance
  always @(posedge clk) begin : feed_stream
    ranked_window_t fresh;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        bytes_accepted++;
        if (cross_window_step(s_tdata, fresh)) pending_windows.push_back(fresh);
      end
      if (!s_tvalid || s_tready) begin
        if (byte_backlog.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_backlog.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // window monitor: random backpressure, compare against the oldest prediction
  always @(posedge clk) begin : check_windows
    ranked_window_t want;
    int             k;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (m_tvalid === 1'b1 && m_tready) begin
        if (pending_windows.size() == 0) begin
          flag_mismatch($sformatf("window %h last %b with none predicted", m_tdata, m_tlast));
        end else begin
          want = pending_windows.pop_front();
          windows_checked++;
          if (want.is_last) last_marks++;
          for (k = 0; k < 5; k++) begin
            if (m_tdata[k*PIX_W +: PIX_W] !== want.ranked[k])
              flag_mismatch($sformatf("window %0d sorted_%0d got %h want %h",
                                      windows_checked, k, m_tdata[k*PIX_W +: PIX_W],
                                      want.ranked[k]));
          end
          if (m_tlast !== want.is_last)
            flag_mismatch($sformatf("window %0d last got %b want %b",
                                    windows_checked, m_tlast, want.is_last));
        end
      end
    end
  end

  // queue one byte and move the generator along the raster
  task automatic queue_byte(input pix_t v);
    byte_backlog.push_back(v);
    bytes_queued++;
    advance_position(gen_col, gen_row, gen_ch);
  endtask

  function automatic pix_t pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return pix_t'($urandom_range(0, 255));
  endfunction

  task automatic queue_to_image_end();
    do queue_byte(pick_byte());
    while (gen_col != 0 || gen_row != 0 || gen_ch != 0);
  endtask

  // the sender stays paused until every predicted window has come out
  task automatic settle();
    while (byte_backlog.size() != 0 || s_tvalid || pending_windows.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [CH_W-1:0] c);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, DIM_W'(c));
    width_reg  = w;
    height_reg = h;
    chan_reg   = c;
    setups++;
  endtask

  // run timeout
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d windows still predicted", pending_windows.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned reps;
    int unsigned n;
    int unsigned img_bytes;
    int          i;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [CH_W-1:0]  c;
    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      centre_line[i] = '0;
    end
    for (i = 0; i < 3; i++) centre_taps[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // smallest image, checkerboard of the byte extremes, last flag on its one window
    set_geometry(11'd3, 11'd3, 3'd1);
    queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h00);
    queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h00);

    // two channels per pixel: the second byte is noise the block must skip
    set_geometry(11'd3, 11'd3, 3'd2);
    queue_byte(8'd10); queue_byte(8'hFF); queue_byte(8'd50); queue_byte(8'h00);
    queue_byte(8'd20); queue_byte(8'hFF); queue_byte(8'd40); queue_byte(8'h00);
    queue_byte(8'd30); queue_byte(8'hFF); queue_byte(8'd60); queue_byte(8'h00);
    queue_byte(8'd90); queue_byte(8'hFF); queue_byte(8'd5);  queue_byte(8'h00);
    queue_byte(8'd70); queue_byte(8'hFF);

    // widest rows for part of the first row, reached through out-of-range codes
    set_geometry(11'd2047, 11'd3, 3'd0);
    repeat (40) queue_byte(pick_byte());

    // narrow rows with the column past the new width, tallest image for a few rows
    set_geometry(11'd1, 11'd2047, 3'd1);
    repeat (30) queue_byte(pick_byte());

    // random phases: mostly whole images, some partial runs that leave counters mid-image
    while (bytes_queued < ITEM_TARGET) begin
      if (bytes_queued < 300) begin
        tx_idle_pct = 22;
        rx_idle_pct = 56;
      end else if (bytes_queued < 600) begin
        tx_idle_pct = 56;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      r = $urandom_range(0, 99);
      w = (r < 10) ? DIM_W'($urandom_range(0, 2)) : DIM_W'($urandom_range(3, 12));
      r = $urandom_range(0, 99);
      if (r < 10) h = DIM_W'($urandom_range(0, 2));
      else if (r < 16) h = DIM_W'($urandom_range(1024, 2047));
      else h = DIM_W'($urandom_range(3, 6));
      c = CH_W'($urandom_range(0, 7));
      // rows grow only on the first row, so no window reads a never-written store entry
      if (gen_row != 0 && clamp_dim(w, 3, MAX_WIDTH) > eff_width()) w = width_reg;
      set_geometry(w, h, c);
      r         = $urandom_range(0, 99);
      reps      = $urandom_range(0, 1);
      img_bytes = eff_width() * eff_height() * eff_channels();
      if (r < 75 && eff_height() <= 6 &&
          bytes_queued + (reps + 1) * img_bytes <= ITEM_TARGET) begin
        queue_to_image_end();
        repeat (reps) queue_to_image_end();
      end else begin
        n = $urandom_range(1, 2 * eff_width() * eff_channels());
        if (n > ITEM_TARGET - bytes_queued) n = ITEM_TARGET - bytes_queued;
        repeat (n) queue_byte(pick_byte());
      end
    end

    settle();
    $display("covered %0d input transactions and %0d sorted windows, %0d with last set",
             bytes_accepted, windows_checked, last_marks);
    $display("%0d register setups: clamped widths and heights, 1 to 4 channels, %s",
             setups, "reconfiguration mid-image");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/cws_pkg.sv
sv/cws_front.sv
sv/cws_fifo.sv
sv/cws_back.sv
sv/cross_window_sorter.sv
bench/tb_cross_window_sorter.sv
